/* src/cdq_pkg.sv */
// Shared constants and command/status codes for the circular deque block.
`default_nettype none
package cdq_pkg;
  localparam int DEPTH      = 256;
  localparam int WORD_BITS  = 32;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int CMD_BITS   = 2;
  localparam int STAT_BITS  = 2;

  localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;
endpackage
`default_nettype wire

/* src/cdq_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered read data.
`default_nettype none
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold the last read word until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

/* src/circular_deque_indexed_insert_remove.sv */
// Top level of the ring-buffer deque with indexed insert, read, remove and clear.
//
//  channel | signals                                      | dir
//  --------+----------------------------------------------+-----
//  in      | in_valid in_ready in_cmd in_index            | in
//          | in_write_data                                |
//  out     | out_valid out_ready out_read_data out_status | out
//          | out_entry_count                              |
//
// One command at a time. Insert and remove move the entries on the shorter
// side (at most DEPTH/2, one read and one write of the entry store per
// cycle); read, clear and rejected commands move none. Reset clears the
// control state, head pointer, count and output valid; the store is not
// swept. A stalled result sits in the output register while the next
// command is taken, and the block holds in its result state until that
// register frees.
`default_nettype none
module circular_deque_indexed_insert_remove (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [cdq_pkg::CMD_BITS-1:0]     in_cmd,
  input  wire logic [cdq_pkg::CNT_BITS-1:0]     in_index,
  input  wire logic [cdq_pkg::WORD_BITS-1:0]    in_write_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [cdq_pkg::WORD_BITS-1:0]    out_read_data,
  output logic      [cdq_pkg::STAT_BITS-1:0]    out_status,
  output logic      [cdq_pkg::CNT_BITS-1:0]     out_entry_count
);
  import cdq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MOVE, S_FINISH, S_RESULT} state_t;

  state_t                 state_r, state_nxt;
  logic [ADDR_BITS-1:0]   head_r, head_nxt;
  logic [CNT_BITS-1:0]    count_r, count_nxt;
  logic [ADDR_BITS-1:0]   new_head_r, new_head_nxt;
  logic [CNT_BITS-1:0]    new_count_r, new_count_nxt;
  logic [CMD_BITS-1:0]    cmd_r, cmd_nxt;
  logic [STAT_BITS-1:0]   stat_r, stat_nxt;
  logic [WORD_BITS-1:0]   word_r, word_nxt;
  logic [ADDR_BITS-1:0]   ins_slot_r, ins_slot_nxt;
  logic [ADDR_BITS-1:0]   src_r, src_nxt;
  logic [ADDR_BITS-1:0]   dst_r, dst_nxt;
  logic                   dir_up_r, dir_up_nxt;
  logic [CNT_BITS-1:0]    left_r, left_nxt;
  logic                   pend_r, pend_nxt;
  logic [WORD_BITS-1:0]   res_data_r, res_data_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0]   out_data_r, out_data_nxt;
  logic [STAT_BITS-1:0]   out_stat_r, out_stat_nxt;
  logic [CNT_BITS-1:0]    out_cnt_r, out_cnt_nxt;

  logic                   mem_we, mem_re;
  logic [ADDR_BITS-1:0]   mem_wa, mem_ra;
  logic [WORD_BITS-1:0]   mem_wd, mem_rd;

  logic [ADDR_BITS-1:0]   idx_a;
  logic [CNT_BITS-1:0]    half;
  logic                   front;

  cdq_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  assign idx_a = in_index[ADDR_BITS-1:0];
  assign half  = count_r >> 1;
  assign front = in_index < half;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    new_head_nxt  = new_head_r;
    new_count_nxt = new_count_r;
    cmd_nxt       = cmd_r;
    stat_nxt      = stat_r;
    word_nxt      = word_r;
    ins_slot_nxt  = ins_slot_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    dir_up_nxt    = dir_up_r;
    left_nxt      = left_r;
    pend_nxt      = 1'b0;
    res_data_nxt  = res_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    mem_we        = 1'b0;
    mem_wa        = dst_r;
    mem_wd        = mem_rd;
    mem_re        = 1'b0;
    mem_ra        = src_r;
    in_ready      = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt       = in_cmd;
          word_nxt      = in_write_data;
          stat_nxt      = ST_OK;
          new_head_nxt  = head_r;
          new_count_nxt = count_r;
          left_nxt      = '0;
          state_nxt     = S_FINISH;
          case (in_cmd)
            CMD_INSERT: begin
              if (count_r == CNT_BITS'(DEPTH)) begin
                stat_nxt = ST_FULL;
              end else if (in_index > count_r) begin
                stat_nxt = ST_RANGE;
              end else begin
                state_nxt     = S_MOVE;
                new_count_nxt = count_r + 1'b1;
                if (front) begin
                  // shift front entries toward the new head
                  left_nxt     = in_index;
                  src_nxt      = head_r;
                  dir_up_nxt   = 1'b1;
                  new_head_nxt = head_r - 1'b1;
                  ins_slot_nxt = head_r - 1'b1 + idx_a;
                end else begin
                  left_nxt     = count_r - in_index;
                  src_nxt      = head_r + count_r[ADDR_BITS-1:0] - 1'b1;
                  dir_up_nxt   = 1'b0;
                  ins_slot_nxt = head_r + idx_a;
                end
              end
            end
            CMD_READ: begin
              if (in_index >= count_r) begin
                stat_nxt = ST_RANGE;
              end else begin
                mem_re = 1'b1;
                mem_ra = head_r + idx_a;
              end
            end
            CMD_REMOVE: begin
              if (in_index >= count_r) begin
                stat_nxt = ST_RANGE;
              end else begin
                state_nxt     = S_MOVE;
                new_count_nxt = count_r - 1'b1;
                if (front) begin
                  left_nxt     = in_index;
                  src_nxt      = head_r + idx_a - 1'b1;
                  dir_up_nxt   = 1'b0;
                  new_head_nxt = head_r + 1'b1;
                end else begin
                  left_nxt   = count_r - 1'b1 - in_index;
                  src_nxt    = head_r + idx_a + 1'b1;
                  dir_up_nxt = 1'b1;
                end
              end
            end
            default: begin
              new_head_nxt  = '0;
              new_count_nxt = '0;
            end
          endcase
        end
      end
      S_MOVE: begin
        // write back the word read last cycle
        mem_we = pend_r;
        if (left_r != '0) begin
          mem_re   = 1'b1;
          mem_ra   = src_r;
          src_nxt  = dir_up_r ? src_r + 1'b1 : src_r - 1'b1;
          dst_nxt  = dir_up_r ? src_r - 1'b1 : src_r + 1'b1;
          left_nxt = left_r - 1'b1;
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (cmd_r == CMD_INSERT && stat_r == ST_OK) begin
          mem_we = 1'b1;
          mem_wa = ins_slot_r;
          mem_wd = word_r;
        end
        head_nxt     = new_head_r;
        count_nxt    = new_count_r;
        res_data_nxt = (cmd_r == CMD_READ && stat_r == ST_OK) ? mem_rd : '0;
        state_nxt    = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_data_r;
          out_stat_nxt  = stat_r;
          out_cnt_nxt   = count_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
    new_head_r  <= new_head_nxt;
    new_count_r <= new_count_nxt;
    cmd_r       <= cmd_nxt;
    stat_r      <= stat_nxt;
    word_r      <= word_nxt;
    ins_slot_r  <= ins_slot_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    dir_up_r    <= dir_up_nxt;
    res_data_r  <= res_data_nxt;
    out_data_r  <= out_data_nxt;
    out_stat_r  <= out_stat_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_data_r;
  assign out_status      = out_stat_r;
  assign out_entry_count = out_cnt_r;
endmodule
`default_nettype wire
